// File: design/sedc_pkg.sv
// Package for the SOH/EOT deframer with CRC-16 check.
// Holds link symbols, status codes, field types, the result struct and CRC helpers.
// No dependencies.
package sedc_pkg;

    // link symbols
    localparam logic [7:0] SYM_SOH = 8'h01;
    localparam logic [7:0] SYM_EOT = 8'h04;
    localparam logic [7:0] SYM_DLE = 8'h10;

    // frame size limit in decoded bytes, EOT slot included (4 to 128)
    localparam int MAX_FRAME = 64;
    localparam int DCOUNT_W  = 7;

    typedef logic [7:0]          byte_t;
    typedef logic [1:0]          status_t;
    typedef logic [5:0]          len_t;
    typedef logic [15:0]         crc_t;
    typedef logic [DCOUNT_W-1:0] dcount_t;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // frame-end status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_CRC_ERR   = 2'd1;
    localparam status_t ST_TOO_SHORT = 2'd2;
    localparam status_t ST_TOO_LONG  = 2'd3;

    localparam len_t LEN_MAX = 6'd63;

    // one result item
    typedef struct packed {
        logic    kind;
        byte_t   data_byte;
        status_t status;
        len_t    payload_length;
    } res_t;

    // nibble table for polynomial 0x1021
    function automatic crc_t crc_nib_tab(input logic [3:0] k);
        crc_t v;
        case (k)
            4'h0: v = 16'h0000;
            4'h1: v = 16'h1021;
            4'h2: v = 16'h2042;
            4'h3: v = 16'h3063;
            4'h4: v = 16'h4084;
            4'h5: v = 16'h50a5;
            4'h6: v = 16'h60c6;
            4'h7: v = 16'h70e7;
            4'h8: v = 16'h8108;
            4'h9: v = 16'h9129;
            4'ha: v = 16'ha14a;
            4'hb: v = 16'hb16b;
            4'hc: v = 16'hc18c;
            4'hd: v = 16'hd1ad;
            4'he: v = 16'he1ce;
            4'hf: v = 16'hf1ef;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // feed one byte, high nibble first
    function automatic crc_t crc_feed(input crc_t c, input byte_t b);
        crc_t t;
        t = crc_nib_tab(c[15:12] ^ b[7:4]) ^ {c[11:0], 4'h0};
        t = crc_nib_tab(t[15:12] ^ b[3:0]) ^ {t[11:0], 4'h0};
        return t;
    endfunction

endpackage

// File: design/soh_eot_deframer_crc16_check_core.sv
// Top level of the SOH/EOT deframer: DLE unescape, two-byte delay, CRC-16 check.
// Depends on sedc_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | rx_byte
//  output   | out_valid / out_ready| kind, data_byte, status, payload_length
//
// One item per cycle: the frame state, delay and CRC update in the cycle the item
// is accepted, and its result (if any) is registered into the output or skid register.
// A two-entry output (register plus skid) lets in_ready depend only on a flop:
// items keep flowing while one result waits; input stalls once both are full.
// Asynchronous active-low reset returns to waiting for SOH with empty output.
module soh_eot_deframer_crc16_check_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sedc_pkg::byte_t    rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output sedc_pkg::byte_t    data_byte,
    output sedc_pkg::status_t  status,
    output sedc_pkg::len_t     payload_length
);
    import sedc_pkg::*;

    logic    in_frame_reg,  in_frame_next;
    logic    esc_reg,       esc_next;
    logic [1:0] hcount_reg, hcount_next;
    byte_t   held0_reg,     held0_next;
    byte_t   held1_reg,     held1_next;
    crc_t    crc_reg,       crc_next;
    dcount_t dcount_reg,    dcount_next;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    res_t    out_reg;
    res_t    skid_reg;

    logic    in_fire;
    logic    out_fire;
    logic    res_valid;
    res_t    res;
    dcount_t len_full;
    logic [DCOUNT_W:0] dcount_inc;
    logic [15:0] got;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign dcount_inc = {1'b0, dcount_reg} + (DCOUNT_W+1)'(1);
    assign len_full   = dcount_reg - DCOUNT_W'(2);
    assign got        = {held1_reg, held0_reg};

    // frame decode for the accepted item
    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        hcount_next   = hcount_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        crc_next      = crc_reg;
        dcount_next   = dcount_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (in_fire)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == SYM_SOH)
                begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    hcount_next   = 2'd0;
                    crc_next      = '0;
                    dcount_next   = '0;
                end
            end
            else if (!esc_reg && rx_byte == SYM_DLE)
            begin
                esc_next = 1'b1;
            end
            else if (!esc_reg && rx_byte == SYM_EOT)
            begin
                in_frame_next = 1'b0;
                res_valid     = 1'b1;
                res.kind      = KIND_END;
                if (dcount_reg < DCOUNT_W'(3) || hcount_reg < 2'd2)
                begin
                    res.status = ST_TOO_SHORT;
                end
                else
                begin
                    res.status = (got == crc_reg) ? ST_OK : ST_CRC_ERR;
                    res.payload_length = (len_full > DCOUNT_W'(LEN_MAX)) ? LEN_MAX
                                                                         : len_full[5:0];
                end
            end
            else
            begin
                // literal byte
                esc_next = 1'b0;
                if (dcount_inc >= (DCOUNT_W+1)'(MAX_FRAME))
                begin
                    in_frame_next = 1'b0;
                    res_valid     = 1'b1;
                    res.kind      = KIND_END;
                    res.status    = ST_TOO_LONG;
                end
                else
                begin
                    dcount_next = dcount_inc[DCOUNT_W-1:0];
                    if (hcount_reg < 2'd2)
                    begin
                        if (hcount_reg[0])
                            held1_next = rx_byte;
                        else
                            held0_next = rx_byte;
                        hcount_next = hcount_reg + 2'd1;
                    end
                    else
                    begin
                        crc_next       = crc_feed(crc_reg, held0_reg);
                        held0_next     = held1_reg;
                        held1_next     = rx_byte;
                        res_valid      = 1'b1;
                        res.kind       = KIND_DATA;
                        res.data_byte  = held0_reg;
                    end
                end
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            hcount_reg   <= 2'd0;
            crc_reg      <= '0;
            dcount_reg   <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            hcount_reg   <= hcount_next;
            crc_reg      <= crc_next;
            dcount_reg   <= dcount_next;
        end
    end

    // delay bytes, no reset
    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign data_byte      = out_reg.data_byte;
    assign status         = out_reg.status;
    assign payload_length = out_reg.payload_length;

`ifndef SYNTHESIS
    // skid only fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item with output register empty");

    // escape can only be pending inside a frame
    a_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> in_frame_reg)
        else $error("escape pending outside a frame");

    // delay never holds more than two bytes
    a_hcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        hcount_reg <= 2'd2)
        else $error("held count out of range");

    // decoded count stays below the frame limit
    a_dcount_limit: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, dcount_reg} < (DCOUNT_W+1)'(MAX_FRAME))
        else $error("decoded count reached frame limit");

    // payload items carry no status or length
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_DATA) |->
            (out_reg.status == ST_OK && out_reg.payload_length == '0))
        else $error("payload item with status or length set");
`endif

endmodule
